[hdl/gaussian_elimination_solver_defines.svh]
// Assertion macros shared by the arithmetic unit and the sequencer.
// Both macros sample on the rising clock edge and are idle during reset.
`ifndef GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH

// Asserts a property that holds whenever the block is out of reset.
`define GES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Asserts that a condition never occurs.
`define GES_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[hdl/ges_pkg.sv]
`default_nettype none
package ges_pkg;

  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  ORDER_RESET = 5'd14;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_PS_RD, ST_PS_CHK, ST_SW_RDK, ST_SW_RDP, ST_SW_WRK, ST_SW_WRP,
    ST_PV_RD, ST_PV_LD, ST_EL_NEXT, ST_K_NEXT, ST_EL_RD, ST_EL_CHK, ST_EL_DIV,
    ST_EM_RDK, ST_EM_MUL, ST_EM_WAIT, ST_EM_WR, ST_EL_ZERO, ST_BS_RD, ST_BS_ACC,
    ST_BS_RDJ, ST_BS_MUL, ST_BS_WAIT, ST_BS_DRD, ST_BS_DIV, ST_BS_DWAIT,
    ST_OUT_RD, ST_OUT_LD
  } ges_state_e;

  // Arithmetic unit states.
  typedef enum logic [1:0] {
    AR_IDLE, AR_MUL, AR_DIV, AR_FIN
  } arith_state_e;

  typedef enum logic {
    OP_MUL, OP_DIV
  } arith_op_e;

  // Source of data written to the matrix store.
  typedef enum logic [2:0] {
    WS_IN, WS_TMP, WS_RDATA, WS_SUB, WS_ZERO
  } wsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    wsel_e     wr_sel;
    logic      tmp_ld;
    logic      piv_ld;
    logic      f_ld;
    logic      acc_ld;
    logic      acc_sub;
    logic      ar_start;
    arith_op_e ar_op;
    logic      ar_bsub;
    logic      sol_rd;
    logic      sol_wr;
    logic      out_ld;
    logic      out_last;
    logic      out_sing;
  } ges_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rd_zero;
    logic ar_done;
    logic out_busy;
  } ges_sts_t;

  // Applies a sign to a magnitude, saturating on overflow.
  function automatic logic [63:0] q_sat(input logic [63:0] r, input logic neg,
                                        input logic ovf);
    logic [63:0] res;
    if (neg) begin
      res = (ovf || r > Q_MIN) ? Q_MIN : (64'd0 - r);
    end else begin
      res = (ovf || r > Q_MAX) ? Q_MAX : r;
    end
    return res;
  endfunction

  // Saturating subtraction of two Q32.32 values.
  function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    logic [63:0] res;
    s = a - b;
    res = s;
    if (a[63] != b[63] && s[63] != a[63]) begin
      res = a[63] ? Q_MIN : Q_MAX;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[hdl/ges_arith.sv]
`default_nettype none
`include "gaussian_elimination_solver_defines.svh"
// Shared Q32.32 multiply and divide unit. A multiply takes four partial
// products, a divide one quotient bit per cycle.
module ges_arith (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire ges_pkg::arith_op_e  op_i,
  input  wire logic [63:0]         a_i,
  input  wire logic [63:0]         b_i,
  output logic                     done_o,
  output logic [63:0]              res_o
);

  ges_pkg::arith_state_e st_q, st_d;
  ges_pkg::arith_op_e    op_q;
  logic                  neg_q;
  logic [63:0]           xa_q, xb_q;
  logic [127:0]          prod_q, num_q;
  logic [63:0]           rem_q, quo_q;
  logic                  ovf_q;
  logic [6:0]            cnt_q;
  logic [63:0]           res_q;
  logic                  done_q;

  logic [63:0]  mag_a, mag_b;
  logic [31:0]  xh, yh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  trial;
  logic         fit;

  // Operand magnitudes at start.
  assign mag_a = a_i[63] ? (64'd0 - a_i) : a_i;
  assign mag_b = b_i[63] ? (64'd0 - b_i) : b_i;

  // Partial product selection for the multiply.
  always_comb begin
    xh = cnt_q[1] ? xa_q[63:32] : xa_q[31:0];
    yh = cnt_q[0] ? xb_q[63:32] : xb_q[31:0];
    pp = 64'(xh) * 64'(yh);
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // One restoring division step.
  assign trial = {rem_q, num_q[127]};
  assign fit   = trial >= {1'b0, xb_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      ges_pkg::AR_IDLE: begin
        if (start_i) begin
          if (op_i == ges_pkg::OP_MUL) begin
            st_d = ges_pkg::AR_MUL;
          end else if (b_i == 64'd0) begin
            st_d = ges_pkg::AR_FIN;
          end else begin
            st_d = ges_pkg::AR_DIV;
          end
        end
      end
      ges_pkg::AR_MUL: if (cnt_q[1:0] == 2'd3) st_d = ges_pkg::AR_FIN;
      ges_pkg::AR_DIV: if (cnt_q == 7'd127) st_d = ges_pkg::AR_FIN;
      ges_pkg::AR_FIN: st_d = ges_pkg::AR_IDLE;
      default: st_d = ges_pkg::AR_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ges_pkg::AR_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == ges_pkg::AR_FIN);
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      ges_pkg::AR_IDLE: begin
        if (start_i) begin
          op_q   <= op_i;
          neg_q  <= a_i[63] ^ b_i[63];
          xa_q   <= mag_a;
          xb_q   <= mag_b;
          prod_q <= '0;
          num_q  <= {32'd0, mag_a, 32'd0};
          rem_q  <= '0;
          quo_q  <= '0;
          ovf_q  <= (op_i == ges_pkg::OP_DIV) && (b_i == 64'd0);
          cnt_q  <= '0;
        end
      end
      ges_pkg::AR_MUL: begin
        prod_q <= prod_q + pp_sh;
        cnt_q  <= cnt_q + 7'd1;
      end
      ges_pkg::AR_DIV: begin
        num_q <= {num_q[126:0], 1'b0};
        rem_q <= fit ? 64'(trial - {1'b0, xb_q}) : trial[63:0];
        quo_q <= {quo_q[62:0], fit};
        if (fit && !cnt_q[6]) ovf_q <= 1'b1;
        cnt_q <= cnt_q + 7'd1;
      end
      ges_pkg::AR_FIN: begin
        if (op_q == ges_pkg::OP_MUL) begin
          res_q <= ges_pkg::q_sat(prod_q[95:32], neg_q, |prod_q[127:96]);
        end else begin
          res_q <= ges_pkg::q_sat(quo_q, neg_q, ovf_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `GES_NEVER(a_start_busy, start_i && st_q != ges_pkg::AR_IDLE, "arith start while busy")
  `GES_ASSERT(a_done_pulse, done_q |=> !done_q, "arith done longer than one cycle")

endmodule
`default_nettype wire

[hdl/ges_datapath.sv]
`default_nettype none
// Matrix and solution stores, working registers and the output register.
module ges_datapath #(
  parameter int MAX_ORDER = 16,
  parameter int AW = 9,
  parameter int RW = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ges_pkg::ges_cmd_t cmd_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [RW-1:0]     sol_addr_i,
  input  wire logic [3:0]        out_idx_i,
  input  wire logic [63:0]       value_i,
  input  wire logic              out_ready_i,
  output ges_pkg::ges_sts_t      sts_o,
  output logic                   out_valid_o,
  output logic [3:0]             unknown_index_o,
  output logic [63:0]            solution_value_o,
  output logic                   singular_o,
  output logic                   last_o
);

  localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1);

  logic [63:0] mat_mem [DEPTH];
  logic [63:0] sol_mem [MAX_ORDER];
  logic [63:0] rdata_q, sol_rdata_q;
  logic [63:0] tmp_q, piv_q, f_q, acc_q;
  logic [63:0] wdata, ar_a, ar_b, ar_res;
  logic        ar_done;
  logic        out_valid_q;
  logic [3:0]  idx_q;
  logic [63:0] val_q;
  logic        sing_q, last_q;

  // Operand selection for the arithmetic unit.
  always_comb begin
    if (cmd_i.ar_op == ges_pkg::OP_MUL) begin
      ar_a = cmd_i.ar_bsub ? rdata_q : f_q;
      ar_b = cmd_i.ar_bsub ? sol_rdata_q : rdata_q;
    end else begin
      ar_a = cmd_i.ar_bsub ? acc_q : rdata_q;
      ar_b = cmd_i.ar_bsub ? rdata_q : piv_q;
    end
  end

  ges_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ar_start),
    .op_i    (cmd_i.ar_op),
    .a_i     (ar_a),
    .b_i     (ar_b),
    .done_o  (ar_done),
    .res_o   (ar_res)
  );

  // Write data for the matrix store.
  always_comb begin
    case (cmd_i.wr_sel)
      ges_pkg::WS_IN:    wdata = value_i;
      ges_pkg::WS_TMP:   wdata = tmp_q;
      ges_pkg::WS_RDATA: wdata = rdata_q;
      ges_pkg::WS_SUB:   wdata = ges_pkg::q_sub(rdata_q, ar_res);
      default:           wdata = 64'd0;
    endcase
  end

  // Stores and working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mat_mem[wr_addr_i] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mat_mem[rd_addr_i];
    if (cmd_i.sol_wr) sol_mem[sol_addr_i] <= ar_res;
    if (cmd_i.sol_rd) sol_rdata_q <= sol_mem[sol_addr_i];
    if (cmd_i.tmp_ld) tmp_q <= rdata_q;
    if (cmd_i.piv_ld) piv_q <= rdata_q;
    if (cmd_i.f_ld) f_q <= ar_res;
    if (cmd_i.acc_ld) acc_q <= cmd_i.acc_sub ? ges_pkg::q_sub(acc_q, ar_res) : rdata_q;
    if (cmd_i.out_ld) begin
      idx_q  <= out_idx_i;
      val_q  <= cmd_i.out_sing ? 64'd0 : sol_rdata_q;
      sing_q <= cmd_i.out_sing;
      last_q <= cmd_i.out_last;
    end
  end

  // Output request valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.rd_zero  = (rdata_q == 64'd0);
  assign sts_o.ar_done  = ar_done;
  assign sts_o.out_busy = out_valid_q;

  assign out_valid_o      = out_valid_q;
  assign unknown_index_o  = idx_q;
  assign solution_value_o = val_q;
  assign singular_o       = sing_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire

[hdl/ges_ctrl.sv]
`default_nettype none
`include "gaussian_elimination_solver_defines.svh"
// Sequencer for load, elimination, back substitution and result output.
module ges_ctrl #(
  parameter int MAX_ORDER = 16,
  parameter int AW = 9,
  parameter int RW = 4,
  parameter int CW = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [3:0]        row_i,
  input  wire logic [4:0]        column_i,
  input  wire logic              cfg_we_i,
  input  wire logic [4:0]        cfg_wdata_i,
  input  wire ges_pkg::ges_sts_t sts_i,
  output ges_pkg::ges_cmd_t      cmd_o,
  output logic [AW-1:0]          rd_addr_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [RW-1:0]          sol_addr_o,
  output logic [3:0]             out_idx_o
);

  localparam int ROW_LEN = MAX_ORDER + 1;

  ges_pkg::ges_state_e state_q, state_d;
  logic [4:0]    order_q;
  logic [CW-1:0] n_q, n_d, k_q, k_d, i_q, i_d, j_q, j_d, p_q, p_d;
  logic          sing_q, sing_d;
  logic [CW-1:0] n_clamp;
  logic          accept, load_ok;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * ROW_LEN + int'(c));
  endfunction

  // Order register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ges_pkg::ORDER_RESET;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  // Order in use, held inside the supported range.
  always_comb begin
    if (order_q == 5'd0) begin
      n_clamp = CW'(1);
    end else if (int'(order_q) > MAX_ORDER) begin
      n_clamp = CW'(MAX_ORDER);
    end else begin
      n_clamp = CW'(order_q);
    end
  end

  assign in_ready_o = (state_q == ges_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_ok    = (int'(row_i) < MAX_ORDER) && (int'(column_i) <= MAX_ORDER);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    k_d        = k_q;
    i_d        = i_q;
    j_d        = j_q;
    p_d        = p_q;
    sing_d     = sing_q;
    cmd_o      = '0;
    rd_addr_o  = addr(k_q, k_q);
    wr_addr_o  = addr(i_q, j_q);
    sol_addr_o = RW'(j_q);
    out_idx_o  = 4'(k_q);
    case (state_q)
      ges_pkg::ST_IDLE: begin
        wr_addr_o = addr(CW'(row_i), CW'(column_i));
        if (accept && !cmd_i) begin
          cmd_o.wr_en  = load_ok;
          cmd_o.wr_sel = ges_pkg::WS_IN;
        end else if (accept) begin
          n_d     = n_clamp;
          k_d     = '0;
          p_d     = '0;
          sing_d  = 1'b0;
          state_d = ges_pkg::ST_PS_RD;
        end
      end
      // Pivot search down the column.
      ges_pkg::ST_PS_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(p_q, k_q);
        state_d     = ges_pkg::ST_PS_CHK;
      end
      ges_pkg::ST_PS_CHK: begin
        j_d = '0;
        if (!sts_i.rd_zero) begin
          state_d = (p_q == k_q) ? ges_pkg::ST_PV_RD : ges_pkg::ST_SW_RDK;
        end else if (p_q + CW'(1) == n_q) begin
          sing_d  = 1'b1;
          k_d     = '0;
          state_d = ges_pkg::ST_OUT_RD;
        end else begin
          p_d     = p_q + CW'(1);
          state_d = ges_pkg::ST_PS_RD;
        end
      end
      // Row swap, one entry at a time.
      ges_pkg::ST_SW_RDK: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(k_q, j_q);
        state_d     = ges_pkg::ST_SW_RDP;
      end
      ges_pkg::ST_SW_RDP: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        rd_addr_o    = addr(p_q, j_q);
        state_d      = ges_pkg::ST_SW_WRK;
      end
      ges_pkg::ST_SW_WRK: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ges_pkg::WS_RDATA;
        wr_addr_o    = addr(k_q, j_q);
        state_d      = ges_pkg::ST_SW_WRP;
      end
      ges_pkg::ST_SW_WRP: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ges_pkg::WS_TMP;
        wr_addr_o    = addr(p_q, j_q);
        if (j_q == CW'(MAX_ORDER)) begin
          state_d = ges_pkg::ST_PV_RD;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = ges_pkg::ST_SW_RDK;
        end
      end
      // Pivot load.
      ges_pkg::ST_PV_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(k_q, k_q);
        state_d     = ges_pkg::ST_PV_LD;
      end
      ges_pkg::ST_PV_LD: begin
        cmd_o.piv_ld = 1'b1;
        i_d          = k_q;
        state_d      = ges_pkg::ST_EL_NEXT;
      end
      ges_pkg::ST_EL_NEXT: begin
        if (i_q + CW'(1) == n_q) begin
          state_d = ges_pkg::ST_K_NEXT;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = ges_pkg::ST_EL_RD;
        end
      end
      ges_pkg::ST_K_NEXT: begin
        if (k_q + CW'(1) == n_q) begin
          i_d     = n_q - CW'(1);
          state_d = ges_pkg::ST_BS_RD;
        end else begin
          k_d     = k_q + CW'(1);
          p_d     = k_q + CW'(1);
          state_d = ges_pkg::ST_PS_RD;
        end
      end
      // Row elimination below the pivot.
      ges_pkg::ST_EL_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(i_q, k_q);
        state_d     = ges_pkg::ST_EL_CHK;
      end
      ges_pkg::ST_EL_CHK: begin
        if (sts_i.rd_zero) begin
          state_d = ges_pkg::ST_EL_NEXT;
        end else begin
          cmd_o.ar_start = 1'b1;
          cmd_o.ar_op    = ges_pkg::OP_DIV;
          state_d        = ges_pkg::ST_EL_DIV;
        end
      end
      ges_pkg::ST_EL_DIV: begin
        if (sts_i.ar_done) begin
          cmd_o.f_ld = 1'b1;
          j_d        = k_q + CW'(1);
          state_d    = ges_pkg::ST_EM_RDK;
        end
      end
      ges_pkg::ST_EM_RDK: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(k_q, j_q);
        state_d     = ges_pkg::ST_EM_MUL;
      end
      ges_pkg::ST_EM_MUL: begin
        cmd_o.ar_start = 1'b1;
        cmd_o.ar_op    = ges_pkg::OP_MUL;
        state_d        = ges_pkg::ST_EM_WAIT;
      end
      ges_pkg::ST_EM_WAIT: begin
        if (sts_i.ar_done) begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = addr(i_q, j_q);
          state_d     = ges_pkg::ST_EM_WR;
        end
      end
      ges_pkg::ST_EM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ges_pkg::WS_SUB;
        wr_addr_o    = addr(i_q, j_q);
        if (j_q == n_q) begin
          state_d = ges_pkg::ST_EL_ZERO;
        end else begin
          j_d     = j_q + CW'(1);
          state_d = ges_pkg::ST_EM_RDK;
        end
      end
      ges_pkg::ST_EL_ZERO: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = ges_pkg::WS_ZERO;
        wr_addr_o    = addr(i_q, k_q);
        state_d      = ges_pkg::ST_EL_NEXT;
      end
      // Back substitution, last unknown first.
      ges_pkg::ST_BS_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(i_q, n_q);
        state_d     = ges_pkg::ST_BS_ACC;
      end
      ges_pkg::ST_BS_ACC: begin
        cmd_o.acc_ld = 1'b1;
        j_d          = i_q + CW'(1);
        state_d      = (i_q + CW'(1) == n_q) ? ges_pkg::ST_BS_DRD : ges_pkg::ST_BS_RDJ;
      end
      ges_pkg::ST_BS_RDJ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.sol_rd = 1'b1;
        rd_addr_o    = addr(i_q, j_q);
        state_d      = ges_pkg::ST_BS_MUL;
      end
      ges_pkg::ST_BS_MUL: begin
        cmd_o.ar_start = 1'b1;
        cmd_o.ar_op    = ges_pkg::OP_MUL;
        cmd_o.ar_bsub  = 1'b1;
        state_d        = ges_pkg::ST_BS_WAIT;
      end
      ges_pkg::ST_BS_WAIT: begin
        if (sts_i.ar_done) begin
          cmd_o.acc_ld  = 1'b1;
          cmd_o.acc_sub = 1'b1;
          if (j_q + CW'(1) == n_q) begin
            state_d = ges_pkg::ST_BS_DRD;
          end else begin
            j_d     = j_q + CW'(1);
            state_d = ges_pkg::ST_BS_RDJ;
          end
        end
      end
      ges_pkg::ST_BS_DRD: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = addr(i_q, i_q);
        state_d     = ges_pkg::ST_BS_DIV;
      end
      ges_pkg::ST_BS_DIV: begin
        cmd_o.ar_start = 1'b1;
        cmd_o.ar_op    = ges_pkg::OP_DIV;
        cmd_o.ar_bsub  = 1'b1;
        state_d        = ges_pkg::ST_BS_DWAIT;
      end
      ges_pkg::ST_BS_DWAIT: begin
        sol_addr_o = RW'(i_q);
        if (sts_i.ar_done) begin
          cmd_o.sol_wr = 1'b1;
          if (i_q == '0) begin
            k_d     = '0;
            state_d = ges_pkg::ST_OUT_RD;
          end else begin
            i_d     = i_q - CW'(1);
            state_d = ges_pkg::ST_BS_RD;
          end
        end
      end
      // Result output, one request per unknown.
      ges_pkg::ST_OUT_RD: begin
        sol_addr_o = RW'(k_q);
        if (!sts_i.out_busy) begin
          cmd_o.sol_rd = 1'b1;
          state_d      = ges_pkg::ST_OUT_LD;
        end
      end
      ges_pkg::ST_OUT_LD: begin
        cmd_o.out_ld   = 1'b1;
        cmd_o.out_sing = sing_q;
        cmd_o.out_last = (k_q + CW'(1) == n_q);
        if (k_q + CW'(1) == n_q) begin
          state_d = ges_pkg::ST_IDLE;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = ges_pkg::ST_OUT_RD;
        end
      end
      default: state_d = ges_pkg::ST_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ges_pkg::ST_IDLE;
      n_q     <= '0;
      k_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
      sing_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      k_q     <= k_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
      sing_q  <= sing_d;
    end
  end

  `GES_NEVER(a_out_overrun, cmd_o.out_ld && sts_i.out_busy, "result loaded over pending request")
  `GES_ASSERT(a_k_range, state_q != ges_pkg::ST_IDLE |-> k_q < n_q, "pivot column out of range")
  `GES_ASSERT(a_i_below, state_q == ges_pkg::ST_EL_RD |-> i_q > k_q, "eliminated row not below pivot")

endmodule
`default_nettype wire

[hdl/gaussian_elimination_solver.sv]
// Load items are accepted back to back while idle. A solve takes about n*(n-1)/2
// divisions on the shared serial divider plus about n^3/3 multiply-subtract steps
// on the four-step multiplier; results then follow one at a time, each loaded
// once the last has been taken. Input ready is low from a solve until its last
// result is loaded. Reset clears control state and sets the order to 14;
// the matrix and solution stores are not cleared.
`default_nettype none
module gaussian_elimination_solver #(
  parameter int MAX_ORDER = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [3:0]  row_i,
  input  wire logic [4:0]  column_i,
  input  wire logic [63:0] value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       unknown_index_o,
  output logic [63:0]      solution_value_o,
  output logic             singular_o,
  output logic             last_o
);

  localparam int AW = $clog2(MAX_ORDER * (MAX_ORDER + 1));
  localparam int RW = $clog2(MAX_ORDER);
  localparam int CW = $clog2(MAX_ORDER + 1);

  ges_pkg::ges_cmd_t cmd;
  ges_pkg::ges_sts_t sts;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [RW-1:0]     sol_addr;
  logic [3:0]        out_idx;

  // Sequencer.
  ges_ctrl #(.MAX_ORDER(MAX_ORDER), .AW(AW), .RW(RW), .CW(CW)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .sol_addr_o  (sol_addr),
    .out_idx_o   (out_idx)
  );

  // Stores and arithmetic.
  ges_datapath #(.MAX_ORDER(MAX_ORDER), .AW(AW), .RW(RW)) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .wr_addr_i        (wr_addr),
    .sol_addr_i       (sol_addr),
    .out_idx_i        (out_idx),
    .value_i          (value_i),
    .out_ready_i      (out_ready_i),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .unknown_index_o  (unknown_index_o),
    .solution_value_o (solution_value_o),
    .singular_o       (singular_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

[dv/gaussian_elimination_solver_tb.sv]
`default_nettype none
module gaussian_elimination_solver_tb;

  localparam int Order = 16;
  localparam int RowLen = Order + 1;
  localparam int FillRows = 4;
  localparam int ItemTarget = 230;
  localparam int IdleLimit = 20000;
  localparam int HoldCycles = 4000;
  localparam logic [63:0] QOne = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [3:0]  idx;
    logic [63:0] value;
    logic        sing;
    logic        last;
  } solution_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = 1'b0;
  logic [3:0]  row_i = '0;
  logic [4:0]  column_i = '0;
  logic [63:0] value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  unknown_index_o;
  logic [63:0] solution_value_o;
  logic        singular_o;
  logic        last_o;

  // Shadow state of the solver.
  logic [63:0] coeff_mat [Order][RowLen];
  logic [63:0] unknowns [Order];
  logic [4:0]  order_reg = ges_pkg::ORDER_RESET;

  solution_t solutions_due [$];
  int  mismatches = 0;
  int  results_checked = 0;
  int  solves_sent = 0;
  int  singular_seen = 0;
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  hold_requests = 0;
  bit  quiet = 1'b0;

  gaussian_elimination_solver u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .row_i           (row_i),
    .column_i        (column_i),
    .value_i         (value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .unknown_index_o (unknown_index_o),
    .solution_value_o(solution_value_o),
    .singular_o      (singular_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Q32.32 arithmetic with magnitude truncation and saturation.
  function automatic logic [63:0] apply_sign(logic [63:0] mag, bit neg, bit ovf);
    if (neg) begin
      return (ovf || mag > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                     : (64'd0 - mag);
    end
    return (ovf || mag > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : mag;
  endfunction

  function automatic logic [63:0] abs_q(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] diff_q(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic logic [63:0] prod_q(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
    return apply_sign(p[95:32], a[63] != b[63], |p[127:96]);
  endfunction

  function automatic logic [63:0] quot_q(logic [63:0] a, logic [63:0] b);
    logic [127:0] num;
    logic [127:0] q;
    if (b == 64'd0) return apply_sign(64'd0, a[63] != b[63], 1'b1);
    num = {32'd0, abs_q(a), 32'd0};
    q = num / {64'd0, abs_q(b)};
    return apply_sign(q[63:0], a[63] != b[63], |q[127:64]);
  endfunction

  // Elimination, back substitution and the expected results of one solve.
  task automatic predict_solution();
    int n;
    int p;
    bit ok;
    logic [63:0] tmp;
    logic [63:0] f;
    logic [63:0] acc;
    n = int'(order_reg);
    if (n < 1) n = 1;
    if (n > Order) n = Order;
    ok = 1'b1;
    for (int k = 0; k < n && ok; k++) begin
      p = k;
      while (p < n && coeff_mat[p][k] == 64'd0) p++;
      if (p == n) begin
        ok = 1'b0;
      end else begin
        if (p != k) begin
          for (int j = 0; j < RowLen; j++) begin
            tmp = coeff_mat[k][j];
            coeff_mat[k][j] = coeff_mat[p][j];
            coeff_mat[p][j] = tmp;
          end
        end
        for (int i = k + 1; i < n; i++) begin
          if (coeff_mat[i][k] != 64'd0) begin
            f = quot_q(coeff_mat[i][k], coeff_mat[k][k]);
            for (int j = k + 1; j <= n; j++) begin
              coeff_mat[i][j] = diff_q(coeff_mat[i][j], prod_q(f, coeff_mat[k][j]));
            end
            coeff_mat[i][k] = 64'd0;
          end
        end
      end
    end
    if (ok) begin
      for (int i = n - 1; i >= 0; i--) begin
        acc = coeff_mat[i][n];
        for (int j = i + 1; j < n; j++) acc = diff_q(acc, prod_q(coeff_mat[i][j], unknowns[j]));
        unknowns[i] = quot_q(acc, coeff_mat[i][i]);
      end
    end else begin
      for (int i = 0; i < Order; i++) unknowns[i] = 64'd0;
    end
    for (int k = 0; k < n; k++) begin
      solutions_due.push_back('{k[3:0], unknowns[k], !ok, k + 1 == n});
    end
  endtask

  // Sends one request, with an optional gap first, and predicts on acceptance.
  task automatic send_request(bit c, logic [3:0] r, logic [4:0] col, logic [63:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    row_i <= r;
    column_i <= col;
    value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (c) begin
      solves_sent++;
      predict_solution();
    end else if (col <= Order) begin
      coeff_mat[r][col] = v;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // The order register is written only once the block has gone idle.
  task automatic write_order(logic [4:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    order_reg = v;
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] frac;
    frac = {32'd0, $urandom()};
    case ($urandom_range(0, 9))
      0: return {$urandom(), $urandom()};
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'd0;
      default: return ({32'd0, $urandom_range(0, 16)} - 64'd8) * QOne + (frac >> 4);
    endcase
  endfunction

  // Loads the n x (n+1) augmented system in use, with some noise requests.
  task automatic load_system(int n, bit zero_col);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c <= n; c++) begin
        send_request(1'b0, r[3:0], c[4:0], (zero_col && c == 0) ? 64'd0 : pick_value());
        if ($urandom_range(0, 15) == 0) begin
          send_request(1'b0, 4'($urandom()), 5'($urandom_range(17, 31)), pick_value());
        end
      end
    end
  endtask

  // The rows used by the smaller systems are written in full, since a row
  // swap moves every column of both rows.
  task automatic test_fill_store();
    for (int r = 0; r < FillRows; r++) begin
      for (int c = 0; c < RowLen; c++) send_request(1'b0, r[3:0], c[4:0], pick_value());
    end
  endtask

  // Extremes, pivot swap, singular system, clamped orders and re-solving.
  task automatic test_directed();
    write_order(5'd1);
    send_request(1'b0, 4'd0, 5'd0, QOne);
    send_request(1'b0, 4'd0, 5'd1, 64'h8000_0000_0000_0000);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    write_order(5'd0);
    send_request(1'b0, 4'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(1'b0, 4'd0, 5'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(1'b1, 4'hF, 5'h1F, 64'hFFFF_FFFF_FFFF_FFFF);
    // Zero on the diagonal forces a row swap.
    write_order(5'd2);
    send_request(1'b0, 4'd0, 5'd0, 64'd0);
    send_request(1'b0, 4'd0, 5'd1, QOne);
    send_request(1'b0, 4'd0, 5'd2, 3 * QOne);
    send_request(1'b0, 4'd1, 5'd0, 2 * QOne);
    send_request(1'b0, 4'd1, 5'd1, 64'd0);
    send_request(1'b0, 4'd1, 5'd2, 4 * QOne);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    // A repeated solve works on the matrix as left behind.
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    // A zero first column makes the system singular.
    send_request(1'b0, 4'd0, 5'd0, 64'd0);
    send_request(1'b0, 4'd1, 5'd0, 64'd0);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    // Loads beyond the last column are ignored; column 16 is stored unused.
    send_request(1'b0, 4'd1, 5'd25, 64'h1234_5678_9ABC_DEF0);
    send_request(1'b0, 4'd15, 5'd16, 64'h8000_0000_0000_0001);
    write_order(5'd3);
    load_system(3, 1'b0);
    write_order(5'd2);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    // An all-zero first column keeps the largest orders singular.
    for (int r = 0; r < Order; r++) send_request(1'b0, r[3:0], 5'd0, 64'd0);
    write_order(5'd31);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    write_order(5'd16);
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
  endtask

  // Random small systems, now and then a singular one or a stale re-solve.
  task automatic test_random_systems();
    int n;
    while (items_sent < ItemTarget) begin
      n = $urandom_range(0, FillRows);
      if (int'(order_reg) != n) write_order(n[4:0]);
      n = (order_reg < 1) ? 1 : int'(order_reg);
      if ($urandom_range(0, 9) != 0) load_system(n, $urandom_range(0, 12) == 0);
      send_request(1'b1, 4'($urandom()), 5'($urandom()), {$urandom(), $urandom()});
    end
  endtask

  // The receiver holds off while loads queue up behind a solve.
  task automatic test_backpressure();
    write_order(5'd4);
    load_system(4, 1'b0);
    hold_requests++;
    send_request(1'b1, 4'd0, 5'd0, 64'd0);
    for (int i = 0; i < 6; i++) send_request(1'b0, 4'($urandom_range(0, 3)), 5'd20, pick_value());
  endtask

  // Closing systems with no idling on either side.
  task automatic test_full_rate();
    drain();
    quiet = 1'b1;
    write_order(5'd3);
    for (int i = 0; i < 3; i++) begin
      load_system(3, 1'b0);
      send_request(1'b1, 4'd0, 5'd0, 64'd0);
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Result checking and receiver stalls.
  initial begin
    int stall_left;
    int hold_left;
    int holds_seen;
    bit ready_next;
    solution_t want;
    stall_left = 0;
    hold_left = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (solutions_due.size() == 0) begin
          report_mismatch("unexpected result", {60'd0, unknown_index_o}, 64'd0);
        end else begin
          want = solutions_due.pop_front();
          if (singular_o) singular_seen++;
          if (unknown_index_o != want.idx) begin
            report_mismatch("index", 64'(unknown_index_o), 64'(want.idx));
          end
          if (solution_value_o != want.value) begin
            report_mismatch("solution", solution_value_o, want.value);
          end
          if (singular_o != want.sing) begin
            report_mismatch("singular", 64'(singular_o), 64'(want.sing));
          end
          if (last_o != want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
        end
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
      end
      out_ready_i <= ready_next;
    end
  end

  // Watchdog on cycles in which no request or result moves.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("gaussian_elimination_solver_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_store();
    test_directed();
    test_backpressure();
    test_random_systems();
    test_full_rate();
    drain();
    $display("Covered %0d solves, %0d results checked, %0d of them singular.",
             solves_sent, results_checked, singular_seen);
    $display("Orders from clamped zero up to clamped 31, with stalls on both sides.");
    if (mismatches == 0) begin
      $display("gaussian_elimination_solver_tb passed");
    end else begin
      $display("gaussian_elimination_solver_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
